// ===== sv/ieqc_pkg.sv =====
// Shared types, constants and helpers for the input event queue.
package ieqc_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

   localparam int KEY_W    = 7;
   localparam int NUM_KEYS = 1 << KEY_W;
   localparam logic [KEY_W-1:0] KEY_LAST = {KEY_W{1'b1}};
   localparam int VAL_W    = 16;
   localparam int FILL_W   = 5;
   localparam int KEEP_W   = 5;

   // modifier keys that a release can keep down
   localparam logic [KEY_W-1:0] KEY_CONTROL = 7'h3B;
   localparam logic [KEY_W-1:0] KEY_CAPS    = 7'h39;
   localparam logic [KEY_W-1:0] KEY_COMMAND = 7'h37;
   localparam logic [KEY_W-1:0] KEY_OPTION  = 7'h3A;
   localparam logic [KEY_W-1:0] KEY_SHIFT   = 7'h38;

   typedef enum logic [2:0] {
      FUNC_KEY     = 3'd0,
      FUNC_BUTTON  = 3'd1,
      FUNC_DELTA   = 3'd2,
      FUNC_POS     = 3'd3,
      FUNC_POP     = 3'd4,
      FUNC_RELEASE = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      KIND_KEY    = 2'd0,
      KIND_BUTTON = 2'd1,
      KIND_DELTA  = 2'd2,
      KIND_POS    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]        func;
      logic [7:0]        key_code;
      logic              is_down;
      logic [VAL_W-1:0]  h_value;
      logic [VAL_W-1:0]  v_value;
      logic [VAL_W-1:0]  current_h;
      logic [VAL_W-1:0]  current_v;
      logic [KEEP_W-1:0] keep_mask;
   } req_word_type;

   typedef struct packed {
      logic             event_valid;
      logic [1:0]       event_kind;
      logic [KEY_W-1:0] event_key;
      logic             event_down;
      logic [VAL_W-1:0] event_h;
      logic [VAL_W-1:0] event_v;
      logic [FILL_W-1:0] fill_level;
      logic             overflowed;
      logic             activity;
   } rsp_word_type;

   typedef struct packed {
      kind_type         kind;
      logic [KEY_W-1:0] key;
      logic             down;
      logic [VAL_W-1:0] h;
      logic [VAL_W-1:0] v;
   } entry_type;

   typedef struct packed {
      logic      rd_en;
      logic      rd_head;    // read head entry, else newest entry
      logic      push;
      logic      overwrite;  // rewrite newest entry
      logic      pop;
      entry_type wdata;
   } ring_ctl_type;

   typedef struct packed {
      logic [FILL_CNT_W-1:0] fill;
      logic                  empty;
      logic                  full;
      kind_type              newest_kind;
      entry_type             rdata;
   } ring_sts_type;

   function automatic logic [KEEP_W-1:0] keep_bit(input logic [KEY_W-1:0] k);
      logic [KEEP_W-1:0] b;
      b = '0;
      if (k == KEY_CONTROL) b = 5'b00001;
      if (k == KEY_CAPS)    b = 5'b00010;
      if (k == KEY_COMMAND) b = 5'b00100;
      if (k == KEY_OPTION)  b = 5'b01000;
      if (k == KEY_SHIFT)   b = 5'b10000;
      return b;
   endfunction

endpackage

// ===== sv/ieqc_ring.sv =====
// Event ring: entry RAM, read/write pointers and fill status.
module ieqc_ring (
   input  logic                  clock,
   input  logic                  reset,
   input  ieqc_pkg::ring_ctl_type ring_ctl,
   output ieqc_pkg::ring_sts_type ring_sts
);

   ieqc_pkg::entry_type event_store_ff [ieqc_pkg::QUEUE_DEPTH];
   ieqc_pkg::entry_type rdata_ff;

   logic [ieqc_pkg::IDX_W-1:0] widx_ff, widx_in, ridx_ff, ridx_in;
   logic [ieqc_pkg::IDX_W-1:0] newest_idx, wr_idx, rd_idx;
   logic                        wwrap_ff, wwrap_in, rwrap_ff, rwrap_in;
   ieqc_pkg::kind_type          last_kind_ff, last_kind_in;
   logic [ieqc_pkg::FILL_CNT_W-1:0] fill;

   assign newest_idx = (widx_ff == '0) ? ieqc_pkg::IDX_LAST : widx_ff - 1'b1;
   assign wr_idx     = ring_ctl.push ? widx_ff : newest_idx;
   assign rd_idx     = ring_ctl.rd_head ? ridx_ff : newest_idx;

   // wrap bits differ once the writer has lapped the reader
   assign fill = ieqc_pkg::FILL_CNT_W'(widx_ff) - ieqc_pkg::FILL_CNT_W'(ridx_ff)
               + ((wwrap_ff != rwrap_ff) ?
                  ieqc_pkg::FILL_CNT_W'(ieqc_pkg::QUEUE_DEPTH) : '0);

   always_comb begin
      widx_in      = widx_ff;
      wwrap_in     = wwrap_ff;
      ridx_in      = ridx_ff;
      rwrap_in     = rwrap_ff;
      last_kind_in = last_kind_ff;
      if (ring_ctl.push) begin
         widx_in  = (widx_ff == ieqc_pkg::IDX_LAST) ? '0 : widx_ff + 1'b1;
         wwrap_in = (widx_ff == ieqc_pkg::IDX_LAST) ? ~wwrap_ff : wwrap_ff;
      end
      if (ring_ctl.pop) begin
         ridx_in  = (ridx_ff == ieqc_pkg::IDX_LAST) ? '0 : ridx_ff + 1'b1;
         rwrap_in = (ridx_ff == ieqc_pkg::IDX_LAST) ? ~rwrap_ff : rwrap_ff;
      end
      if (ring_ctl.push || ring_ctl.overwrite) begin
         last_kind_in = ring_ctl.wdata.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff      <= '0;
         wwrap_ff     <= 1'b0;
         ridx_ff      <= '0;
         rwrap_ff     <= 1'b0;
         last_kind_ff <= ieqc_pkg::KIND_KEY;
      end else begin
         widx_ff      <= widx_in;
         wwrap_ff     <= wwrap_in;
         ridx_ff      <= ridx_in;
         rwrap_ff     <= rwrap_in;
         last_kind_ff <= last_kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_ctl.push || ring_ctl.overwrite) begin
         event_store_ff[wr_idx] <= ring_ctl.wdata;
      end
      if (ring_ctl.rd_en) begin
         rdata_ff <= event_store_ff[rd_idx];
      end
   end

   assign ring_sts.fill        = fill;
   assign ring_sts.empty       = (widx_ff == ridx_ff) && (wwrap_ff == rwrap_ff);
   assign ring_sts.full        = (widx_ff == ridx_ff) && (wwrap_ff != rwrap_ff);
   assign ring_sts.newest_kind = last_kind_ff;
   assign ring_sts.rdata       = rdata_ff;

`ifndef SYNTHESIS
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      ring_ctl.push |-> !ring_sts.full)
      else $error("push into full ring");
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      ring_ctl.pop |-> !ring_sts.empty)
      else $error("pop from empty ring");
   a_overwrite_live: assert property (@(posedge clock) disable iff (reset)
      ring_ctl.overwrite |-> (!ring_sts.empty && !ring_ctl.push))
      else $error("overwrite without a live newest entry");
`endif

endmodule

// ===== sv/input_event_queue_coalescing.sv =====
// Top level: input event queue with key and mouse-button change coalescing.
//
// One request word in, one response word out, per item. Key and button
// changes enqueue an event only when the held state really changes; mouse
// deltas merge into a newest delta entry and positions overwrite a newest
// position entry. Pop returns the head entry. An item is accepted in idle
// and executes after that, one read-modify-write of the event RAM (read
// issued at accept, written back in execute). A release-keys item walks
// the 128-entry key-down map one key per cycle, since each key-up may
// enqueue one entry through the single RAM write port, then finishes; a
// new item is accepted only once the block is back in idle. The response
// sits in an output register; execution waits only while that register is
// still full and not being taken. fill_level is the queue occupancy after
// the item, overflowed is sticky once any allocation found the queue full.
module input_event_queue_coalescing (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ieqc_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ieqc_pkg::rsp_word_type rsp_word
);

   ieqc_pkg::state_type    state_ff, state_in;
   ieqc_pkg::req_word_type req_ff;
   ieqc_pkg::rsp_word_type rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ieqc_pkg::NUM_KEYS-1:0] map_ff, map_in;
   logic                   button_ff, button_in;
   logic                   recover_ff, recover_in;
   logic [ieqc_pkg::KEY_W-1:0] walk_ff, walk_in;
   logic                   act_ff, act_in;

   ieqc_pkg::ring_ctl_type ring_ctl;
   ieqc_pkg::ring_sts_type ring_sts;

   logic accept;
   logic out_free;

   assign req_ready = (state_ff == ieqc_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   ieqc_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .ring_ctl (ring_ctl),
      .ring_sts (ring_sts)
   );

   always_comb begin
      logic [ieqc_pkg::KEY_W-1:0]      code;
      logic                            act;
      logic                            valid;
      logic                            want;
      ieqc_pkg::entry_type             ent;
      ieqc_pkg::entry_type             popped;
      logic [ieqc_pkg::FILL_CNT_W-1:0] fill_after;

      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      map_in       = map_ff;
      button_in    = button_ff;
      recover_in   = recover_ff;
      walk_in      = walk_ff;
      act_in       = act_ff;
      ring_ctl     = '0;
      code         = req_ff.key_code[ieqc_pkg::KEY_W-1:0];
      act          = 1'b0;
      valid        = 1'b0;
      want         = 1'b0;
      ent          = '0;
      popped       = '0;
      fill_after   = ring_sts.fill;

      case (state_ff)
         ieqc_pkg::ST_IDLE: begin
            if (accept) begin
               ring_ctl.rd_en   = 1'b1;
               ring_ctl.rd_head = (req_word.func == ieqc_pkg::FUNC_POP);
               walk_in          = '0;
               act_in           = 1'b0;
               state_in         = ieqc_pkg::ST_EXEC;
            end
         end
         ieqc_pkg::ST_EXEC: begin
            if (out_free) begin
               case (ieqc_pkg::func_type'(req_ff.func))
                  ieqc_pkg::FUNC_KEY: begin
                     if (map_ff[code] != req_ff.is_down) begin
                        act = 1'b1;
                        if (ring_sts.full) begin
                           recover_in = 1'b1;
                        end else begin
                           ent.kind      = ieqc_pkg::KIND_KEY;
                           ent.key       = code;
                           ent.down      = req_ff.is_down;
                           ring_ctl.push = 1'b1;
                           map_in[code]  = req_ff.is_down;
                        end
                     end
                  end
                  ieqc_pkg::FUNC_BUTTON: begin
                     if (button_ff != req_ff.is_down) begin
                        act = 1'b1;
                        if (ring_sts.full) begin
                           recover_in = 1'b1;
                        end else begin
                           ent.kind      = ieqc_pkg::KIND_BUTTON;
                           ent.down      = req_ff.is_down;
                           ring_ctl.push = 1'b1;
                           button_in     = req_ff.is_down;
                        end
                     end
                  end
                  ieqc_pkg::FUNC_DELTA: begin
                     if (req_ff.h_value != '0 || req_ff.v_value != '0) begin
                        act      = 1'b1;
                        ent.kind = ieqc_pkg::KIND_DELTA;
                        if (!ring_sts.empty &&
                            ring_sts.newest_kind == ieqc_pkg::KIND_DELTA) begin
                           // merge into the newest delta, wrapping per axis
                           ent.h              = ring_sts.rdata.h + req_ff.h_value;
                           ent.v              = ring_sts.rdata.v + req_ff.v_value;
                           ring_ctl.overwrite = 1'b1;
                        end else if (ring_sts.full) begin
                           recover_in = 1'b1;
                        end else begin
                           ent.h         = req_ff.h_value;
                           ent.v         = req_ff.v_value;
                           ring_ctl.push = 1'b1;
                        end
                     end
                  end
                  ieqc_pkg::FUNC_POS: begin
                     if (req_ff.h_value != req_ff.current_h ||
                         req_ff.v_value != req_ff.current_v) begin
                        act      = 1'b1;
                        ent.kind = ieqc_pkg::KIND_POS;
                        ent.h    = req_ff.h_value;
                        ent.v    = req_ff.v_value;
                        if (!ring_sts.empty &&
                            ring_sts.newest_kind == ieqc_pkg::KIND_POS) begin
                           ring_ctl.overwrite = 1'b1;
                        end else if (ring_sts.full) begin
                           recover_in = 1'b1;
                        end else begin
                           ring_ctl.push = 1'b1;
                        end
                     end
                  end
                  ieqc_pkg::FUNC_POP: begin
                     if (!ring_sts.empty) begin
                        valid        = 1'b1;
                        popped       = ring_sts.rdata;
                        ring_ctl.pop = 1'b1;
                     end
                  end
                  ieqc_pkg::FUNC_RELEASE: begin
                     want = 1'b1;
                  end
                  default: begin
                  end
               endcase

               ring_ctl.wdata = ent;
               if (ring_ctl.push) begin
                  fill_after = ring_sts.fill + 1'b1;
               end else if (ring_ctl.pop) begin
                  fill_after = ring_sts.fill - 1'b1;
               end

               if (want) begin
                  state_in = ieqc_pkg::ST_WALK;
               end else begin
                  rsp_in.event_valid = valid;
                  rsp_in.event_kind  = popped.kind;
                  rsp_in.event_key   = popped.key;
                  rsp_in.event_down  = popped.down;
                  rsp_in.event_h     = popped.h;
                  rsp_in.event_v     = popped.v;
                  rsp_in.fill_level  = ieqc_pkg::FILL_W'(fill_after);
                  rsp_in.overflowed  = recover_in;
                  rsp_in.activity    = act;
                  rsp_valid_in       = 1'b1;
                  state_in           = ieqc_pkg::ST_IDLE;
               end
            end
         end
         ieqc_pkg::ST_WALK: begin
            // one key per cycle; a key-up that finds the queue full leaves it down
            if (map_ff[walk_ff] &&
                (req_ff.keep_mask & ieqc_pkg::keep_bit(walk_ff)) == '0) begin
               act_in = 1'b1;
               if (ring_sts.full) begin
                  recover_in = 1'b1;
               end else begin
                  ent.kind        = ieqc_pkg::KIND_KEY;
                  ent.key         = walk_ff;
                  ring_ctl.push   = 1'b1;
                  map_in[walk_ff] = 1'b0;
               end
            end
            ring_ctl.wdata = ent;
            if (walk_ff == ieqc_pkg::KEY_LAST) begin
               state_in = ieqc_pkg::ST_FINISH;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         ieqc_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_in             = '0;
               rsp_in.fill_level  = ieqc_pkg::FILL_W'(ring_sts.fill);
               rsp_in.overflowed  = recover_ff;
               rsp_in.activity    = act_ff;
               rsp_valid_in       = 1'b1;
               state_in           = ieqc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ieqc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ieqc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         map_ff       <= '0;
         button_ff    <= 1'b0;
         recover_ff   <= 1'b0;
         walk_ff      <= '0;
         act_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         map_ff       <= map_in;
         button_ff    <= button_in;
         recover_ff   <= recover_in;
         walk_ff      <= walk_in;
         act_ff       <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         req_ff <= req_word;
      end
   end

`ifndef SYNTHESIS
   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      ring_ctl.rd_en |-> !(ring_ctl.push || ring_ctl.overwrite))
      else $error("RAM read issued in a write cycle");
   a_recover_sticky: assert property (@(posedge clock) disable iff (reset)
      recover_ff |=> recover_ff)
      else $error("overflow flag cleared");
   a_walk_full_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ieqc_pkg::ST_WALK && walk_ff != ieqc_pkg::KEY_LAST)
      |=> (state_ff == ieqc_pkg::ST_WALK))
      else $error("release walk ended early");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the input event queue with change coalescing.
module tb_top;
   import ieqc_pkg::*;

   // func codes the block treats as no-ops
   localparam logic [2:0] FUNC_SPARE_A = 3'd6;
   localparam logic [2:0] FUNC_SPARE_B = 3'd7;

   localparam int RANDOM_PER_SET = 550;     // three idle settings, ~1650 words
   localparam int DRAIN_CYCLES   = 200;     // longer than a full release walk
   localparam int CYCLE_LIMIT    = 600000;

   // one stimulus word plus the idle setting it runs under
   typedef struct {
      req_word_type word;
      int           idle_set;
   } pending_word_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   input_event_queue_coalescing uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the block state: event ring, pointers that run modulo
   // twice the depth, held keys, held mouse button, sticky overflow.
   // ---------------------------------------------------------------------
   entry_type        ev_ring [QUEUE_DEPTH];
   logic [IDX_W:0]   wr_idx        = '0;
   logic [IDX_W:0]   rd_idx        = '0;
   logic [NUM_KEYS-1:0] keys_held  = '0;
   logic             button_held   = 1'b0;
   logic             overflow_seen = 1'b0;

   pending_word_type pending_words [$];
   rsp_word_type     expected_events [$];
   pending_word_type next_word;

   int accepted_cnt = 0;
   int checked_cnt  = 0;
   int err_cnt      = 0;
   int cycle_cnt    = 0;
   int rx_idle_pct  = 0;

   task automatic report_error(input string msg);
      $display("ERROR @%0d: %s", cycle_cnt, msg);
      err_cnt++;
   endtask

   function automatic int ring_count();
      logic [IDX_W:0] diff;
      diff = wr_idx - rd_idx;
      return int'(diff);
   endfunction

   // slot of the newest unconsumed entry, -1 when the ring is empty
   function automatic int newest_slot();
      logic [IDX_W:0] p;
      if (ring_count() == 0) return -1;
      p = wr_idx - 1'b1;
      return int'(p[IDX_W-1:0]);
   endfunction

   // allocate a cleared slot; a full ring sets the sticky flag instead
   function automatic int grab_slot();
      int slot;
      if (ring_count() >= QUEUE_DEPTH) begin
         overflow_seen = 1'b1;
         return -1;
      end
      slot = int'(wr_idx[IDX_W-1:0]);
      ev_ring[slot] = '0;
      wr_idx = wr_idx + 1'b1;
      return slot;
   endfunction

   // returns activity: the held state differed, queued or not
   function automatic logic key_toggle(input logic [KEY_W-1:0] code, input logic dn);
      int slot;
      if (keys_held[code] == dn) return 1'b0;
      slot = grab_slot();
      if (slot >= 0) begin
         ev_ring[slot].kind = KIND_KEY;
         ev_ring[slot].key  = code;
         ev_ring[slot].down = dn;
         keys_held[code]    = dn;
      end
      return 1'b1;
   endfunction

   function automatic logic [KEEP_W-1:0] modifier_guard(input logic [KEY_W-1:0] code);
      case (code)
         KEY_CONTROL: return 5'b00001;
         KEY_CAPS:    return 5'b00010;
         KEY_COMMAND: return 5'b00100;
         KEY_OPTION:  return 5'b01000;
         KEY_SHIFT:   return 5'b10000;
         default:     return '0;
      endcase
   endfunction

   // advance the shadow state by one word and build the response it causes
   function automatic rsp_word_type predict_event(input req_word_type w);
      rsp_word_type r;
      int           slot;
      logic         act;
      r   = '0;
      act = 1'b0;
      case (w.func)
         FUNC_KEY: begin
            act = key_toggle(w.key_code[KEY_W-1:0], w.is_down);
         end
         FUNC_BUTTON: begin
            if (button_held != w.is_down) begin
               slot = grab_slot();
               if (slot >= 0) begin
                  ev_ring[slot].kind = KIND_BUTTON;
                  ev_ring[slot].down = w.is_down;
                  button_held        = w.is_down;
               end
               act = 1'b1;
            end
         end
         FUNC_DELTA: begin
            if (w.h_value != '0 || w.v_value != '0) begin
               slot = newest_slot();
               if (slot >= 0 && ev_ring[slot].kind == KIND_DELTA) begin
                  // merge, wrapping per axis
                  ev_ring[slot].h = ev_ring[slot].h + w.h_value;
                  ev_ring[slot].v = ev_ring[slot].v + w.v_value;
               end else begin
                  slot = grab_slot();
                  if (slot >= 0) begin
                     ev_ring[slot].kind = KIND_DELTA;
                     ev_ring[slot].h    = w.h_value;
                     ev_ring[slot].v    = w.v_value;
                  end
               end
               act = 1'b1;
            end
         end
         FUNC_POS: begin
            if (w.h_value != w.current_h || w.v_value != w.current_v) begin
               slot = newest_slot();
               if (slot < 0 || ev_ring[slot].kind != KIND_POS) slot = grab_slot();
               if (slot >= 0) begin
                  ev_ring[slot]      = '0;
                  ev_ring[slot].kind = KIND_POS;
                  ev_ring[slot].h    = w.h_value;
                  ev_ring[slot].v    = w.v_value;
               end
               act = 1'b1;
            end
         end
         FUNC_POP: begin
            if (ring_count() != 0) begin
               slot          = int'(rd_idx[IDX_W-1:0]);
               r.event_valid = 1'b1;
               r.event_kind  = ev_ring[slot].kind;
               r.event_key   = ev_ring[slot].key;
               r.event_down  = ev_ring[slot].down;
               r.event_h     = ev_ring[slot].h;
               r.event_v     = ev_ring[slot].v;
               rd_idx        = rd_idx + 1'b1;
            end
         end
         FUNC_RELEASE: begin
            // key-up for every held key not protected by the keep mask;
            // keys that hit a full ring stay down
            for (int k = 0; k < NUM_KEYS; k++) begin
               if (keys_held[k] && (w.keep_mask & modifier_guard(KEY_W'(k))) == '0) begin
                  if (key_toggle(KEY_W'(k), 1'b0)) act = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.fill_level = FILL_W'(ring_count());
      r.overflowed = overflow_seen;
      r.activity   = act;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int tx_idle_pct(input int idle_set);
      case (idle_set)
         0:       return 37;
         1:       return 56;
         default: return 0;
      endcase
   endfunction

   function automatic int rx_pct_of(input int idle_set);
      case (idle_set)
         0:       return 56;
         1:       return 37;
         default: return 0;
      endcase
   endfunction

   function automatic req_word_type make_word(input logic [2:0] fn, input logic [7:0] code,
                                              input logic dn, input logic [15:0] h,
                                              input logic [15:0] v, input logic [15:0] ch,
                                              input logic [15:0] cv, input logic [4:0] keep);
      req_word_type w;
      w.func      = fn;
      w.key_code  = code;
      w.is_down   = dn;
      w.h_value   = h;
      w.v_value   = v;
      w.current_h = ch;
      w.current_v = cv;
      w.keep_mask = keep;
      return w;
   endfunction

   // keys drawn mostly from a small set so that presses and releases really
   // toggle held state; top bit of the code is random to prove it is ignored
   function automatic logic [7:0] pick_key();
      logic [KEY_W-1:0] code;
      if ($urandom_range(0, 99) < 25) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 8))
         0:       code = KEY_CONTROL;
         1:       code = KEY_CAPS;
         2:       code = KEY_COMMAND;
         3:       code = KEY_OPTION;
         4:       code = KEY_SHIFT;
         5:       code = '0;
         6:       code = KEY_LAST;
         default: code = KEY_W'($urandom_range(0, 15));
      endcase
      return {1'($urandom_range(0, 1)), code};
   endfunction

   function automatic logic [15:0] pick_delta();
      if ($urandom_range(0, 1) == 1) return 16'($urandom_range(0, 65535));
      return 16'(int'($urandom_range(0, 16)) - 8);   // small signed step
   endfunction

   // one random word; every field is randomized first so all bits toggle,
   // then the fields that matter for the chosen function are shaped
   function automatic req_word_type random_event(input int pop_pct);
      req_word_type w;
      int           pick;
      w = make_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)));
      if ($urandom_range(0, 99) < pop_pct) begin
         w.func = FUNC_POP;
         return w;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         w.func = FUNC_RELEASE;
      end else if (pick < 4) begin
         w.func = ($urandom_range(0, 1) == 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
      end else if (pick < 44) begin
         w.func     = FUNC_KEY;
         w.key_code = pick_key();
      end else if (pick < 56) begin
         w.func = FUNC_BUTTON;
      end else if (pick < 78) begin
         w.func    = FUNC_DELTA;
         w.h_value = pick_delta();
         w.v_value = pick_delta();
         if ($urandom_range(0, 7) == 0) begin
            w.h_value = '0;
            w.v_value = '0;
         end
      end else begin
         w.func = FUNC_POS;
         case ($urandom_range(0, 5))
            0: begin
               w.current_h = w.h_value;
               w.current_v = w.v_value;
            end
            1: w.current_h = w.h_value;
            2: w.current_v = w.v_value;
            default: ;
         endcase
      end
      return w;
   endfunction

   function automatic void queue_word(input req_word_type w, input int idle_set);
      pending_word_type p;
      p.word     = w;
      p.idle_set = idle_set;
      pending_words.push_back(p);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents pending words; the prediction is taken at the edge
   // the word is accepted, so the shadow state advances in block order.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_events.push_back(predict_event(req_word));
            accepted_cnt <= accepted_cnt + 1;
         end
         // only move on once the current word is gone; valid is never
         // dropped while a word waits
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 &&
                $urandom_range(0, 99) >= tx_idle_pct(pending_words[0].idle_set)) begin
               next_word    = pending_words.pop_front();
               req_valid   <= 1'b1;
               req_word    <= next_word.word;
               rx_idle_pct <= rx_pct_of(next_word.idle_set);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each taken response against the oldest prediction.
   // accepted_cnt is read before this edge's update, so a prediction pushed
   // at this same edge never counts as waiting.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (checked_cnt < accepted_cnt) begin
               rsp_word_type want;
               want = expected_events.pop_front();
               checked_cnt <= checked_cnt + 1;
               if (rsp_word.event_valid !== want.event_valid)
                  report_error($sformatf("event_valid got %b want %b",
                                         rsp_word.event_valid, want.event_valid));
               if (rsp_word.event_kind !== want.event_kind)
                  report_error($sformatf("event_kind got %0d want %0d",
                                         rsp_word.event_kind, want.event_kind));
               if (rsp_word.event_key !== want.event_key)
                  report_error($sformatf("event_key got %h want %h",
                                         rsp_word.event_key, want.event_key));
               if (rsp_word.event_down !== want.event_down)
                  report_error($sformatf("event_down got %b want %b",
                                         rsp_word.event_down, want.event_down));
               if (rsp_word.event_h !== want.event_h)
                  report_error($sformatf("event_h got %h want %h",
                                         rsp_word.event_h, want.event_h));
               if (rsp_word.event_v !== want.event_v)
                  report_error($sformatf("event_v got %h want %h",
                                         rsp_word.event_v, want.event_v));
               if (rsp_word.fill_level !== want.fill_level)
                  report_error($sformatf("fill_level got %0d want %0d",
                                         rsp_word.fill_level, want.fill_level));
               if (rsp_word.overflowed !== want.overflowed)
                  report_error($sformatf("overflowed got %b want %b",
                                         rsp_word.overflowed, want.overflowed));
               if (rsp_word.activity !== want.activity)
                  report_error($sformatf("activity got %b want %b",
                                         rsp_word.activity, want.activity));
            end else begin
               report_error("response word with no prediction waiting");
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
   end

   initial begin
      wait (cycle_cnt >= CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      int burst;
      int pop_pct;
      int sent;

      // directed part, run under the first idle setting
      queue_word(make_word(FUNC_POP, 8'h00, 1'b0, '0, '0, '0, '0, '0), 0);        // empty pop
      queue_word(make_word(FUNC_KEY, 8'h00, 1'b1, '0, '0, '0, '0, '0), 0);
      queue_word(make_word(FUNC_KEY, 8'hFF, 1'b1, '0, '0, '0, '0, '0), 0);        // top bit dropped
      queue_word(make_word(FUNC_KEY, 8'h7F, 1'b1, '0, '0, '0, '0, '0), 0);        // no change
      queue_word(make_word(FUNC_KEY, {1'b0, KEY_CONTROL}, 1'b1, '0, '0, '0, '0, '0), 0);
      queue_word(make_word(FUNC_KEY, {1'b0, KEY_SHIFT}, 1'b1, '0, '0, '0, '0, '0), 0);
      queue_word(make_word(FUNC_BUTTON, 8'h00, 1'b1, '0, '0, '0, '0, '0), 0);
      queue_word(make_word(FUNC_BUTTON, 8'h00, 1'b1, '0, '0, '0, '0, '0), 0);     // no change
      queue_word(make_word(FUNC_BUTTON, 8'h00, 1'b0, '0, '0, '0, '0, '0), 0);
      queue_word(make_word(FUNC_DELTA, 8'h00, 1'b0, 16'hFFFF, 16'h0001, '0, '0, '0), 0);
      queue_word(make_word(FUNC_DELTA, 8'h00, 1'b0, 16'h0001, 16'hFFFF, '0, '0, '0), 0); // wraps
      queue_word(make_word(FUNC_DELTA, 8'h00, 1'b0, '0, '0, '0, '0, '0), 0);      // zero delta
      queue_word(make_word(FUNC_POS, 8'h00, 1'b0, 16'hABCD, 16'hABCD,
                           16'hABCD, 16'hABCD, '0), 0);                          // unchanged
      queue_word(make_word(FUNC_POS, 8'h00, 1'b0, 16'h1234, 16'hFFFF, '0, '0, '0), 0);
      queue_word(make_word(FUNC_POS, 8'h00, 1'b0, 16'h0000, 16'h0000,
                           16'hFFFF, 16'hFFFF, '0), 0);                          // overwrite
      queue_word(make_word(FUNC_SPARE_A, 8'hFF, 1'b1, '1, '1, '1, '1, '1), 0);
      queue_word(make_word(FUNC_SPARE_B, 8'hFF, 1'b1, '1, '1, '1, '1, '1), 0);
      queue_word(make_word(FUNC_RELEASE, 8'h00, 1'b0, '0, '0, '0, '0, 5'b00001), 0); // keep ctrl
      queue_word(make_word(FUNC_RELEASE, 8'h00, 1'b0, '0, '0, '0, '0, 5'b00000), 0);
      // fill the ring past full: last two presses are dropped, flag sticks
      for (int i = 1; i <= 6; i++)
         queue_word(make_word(FUNC_KEY, 8'(8'h80 | i), 1'b1, '0, '0, '0, '0, '0), 0);
      queue_word(make_word(FUNC_POP, 8'h00, 1'b0, '0, '0, '0, '0, '0), 0);

      // random part: bursts that mostly fill or mostly drain the ring, so
      // fill level sweeps between empty and full under each idle setting
      for (int s = 0; s < 3; s++) begin
         sent = 0;
         while (sent < RANDOM_PER_SET) begin
            burst   = $urandom_range(8, 40);
            pop_pct = ($urandom_range(0, 1) == 1) ? $urandom_range(5, 20)
                                                  : $urandom_range(45, 70);
            for (int i = 0; i < burst && sent < RANDOM_PER_SET; i++) begin
               queue_word(random_event(pop_pct), s);
               sent++;
            end
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (checked_cnt != accepted_cnt) @(posedge clock);
      // catch any stray response after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_events.size() != 0)
         report_error($sformatf("%0d predicted responses never arrived",
                                expected_events.size()));
      if (err_cnt == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
